FILE: sv/led_pixel_spi_encoder_unit_macros.svh
// Assertion macros for the LED pixel SPI encoder.
`ifndef LED_PIXEL_SPI_ENCODER_UNIT_MACROS_SVH
`define LED_PIXEL_SPI_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTH
// Property that holds in the same cycle
`define LPSE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpse assertion failed");
// Antecedent implies consequent in the next cycle
`define LPSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpse assertion failed");
`else
`define LPSE_ASSERT(label, prop)
`define LPSE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/lpse_pkg.sv
// Constants and helper functions for the LED pixel SPI encoder.
package lpse_pkg;

    localparam logic [3:0] LINE_CODE_ONE   = 4'b1110;
    localparam logic [3:0] LINE_CODE_ZERO  = 4'b1000;
    localparam logic [15:0] ROUND_HALF     = 16'd127;
    localparam logic [7:0] FULL_SCALE      = 8'd255;
    localparam logic [7:0] BRIGHT_RESET    = 8'd64;
    localparam logic [6:0] GAP_RESET       = 7'd30;
    localparam logic [6:0] GAP_MAX         = 7'd64;
    localparam logic [6:0] BYTES_PER_PIXEL = 7'd12;

    // Item kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_GAP   = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_GAP_LENGTH = 1'b1;

    // One data bit to its 4-bit line code
    function automatic logic [3:0] line_code(input logic b);
        return b ? LINE_CODE_ONE : LINE_CODE_ZERO;
    endfunction

    // One channel byte to four SPI bytes, MSB first, earlier bit in high nibble
    function automatic logic [31:0] encode_channel(input logic [7:0] v);
        logic [31:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w[31 - 4*i -: 4] = line_code(v[7 - i]);
        end
        return w;
    endfunction

endpackage

FILE: sv/lpse_if.sv
// Stream interfaces: pixel/gap items in, SPI bytes out.
interface lpse_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;

    modport source (output valid, output func, output green, output red, output blue,
                    input ready);
    modport sink   (input valid, input func, input green, input red, input blue,
                    output ready);
endinterface

interface lpse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] spi_byte;
    logic       last_of_run;

    modport source (output valid, output spi_byte, output last_of_run, input ready);
    modport sink   (input valid, input spi_byte, input last_of_run, output ready);
endinterface

FILE: sv/led_pixel_spi_encoder_unit.sv
// Top level of the LED pixel SPI encoder: dimming pipeline and byte serializer.
// A pixel word on item yields 12 SPI bytes on line (green, red, blue, MSB first,
// each bit as a 4-bit line code, two codes per byte); a gap word yields
// gap_length zero bytes (0 counts as 1, above 64 as 64). last_of_run marks the
// final byte of each item. The output serializer sets throughput at one output byte
// per cycle while line.ready is high; a pixel occupies it for 12 bytes, a gap for 1
// to 64 bytes. Two pipeline stages (multiply with rounding offset, then reciprocal
// divide by 255 and line coding) feed it, a word passing the stage-1 and stage-2
// registers first; further words are taken while earlier bytes drain.
// Registers: brightness at 0x0 (reset 64), gap_length at 0x4 (reset 30).
`include "led_pixel_spi_encoder_unit_macros.svh"

module led_pixel_spi_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    lpse_in_if.sink     item,
    lpse_out_if.source  line,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [7:0] brightness_reg;
    logic [6:0] gap_length_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= lpse_pkg::BRIGHT_RESET;
            gap_length_reg <= lpse_pkg::GAP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                lpse_pkg::REG_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                lpse_pkg::REG_GAP_LENGTH: gap_length_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lpse_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness_reg};
            lpse_pkg::REG_GAP_LENGTH: prdata = {25'd0, gap_length_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [95:0] data_reg;
    logic [95:0] data_next;
    logic        out_fire;
    logic        ser_load;
    logic        adv2;
    logic        adv1;

    assign out_fire = line.valid && line.ready;
    assign ser_load = s2_valid_reg && ((cnt_reg == 7'd0) || ((cnt_reg == 7'd1) && out_fire));
    assign adv2     = !s2_valid_reg || ser_load;
    assign adv1     = !s1_valid_reg || adv2;
    assign item.ready = adv1;

    // ---------------- stage 1: products plus rounding offset ----------------
    logic        s1_func_reg;
    logic        s1_bypass_reg;
    logic [7:0]  s1_raw_reg [3];
    logic [15:0] s1_sum_reg [3];
    logic [7:0]  in_ch [3];

    assign in_ch[0] = item.green;
    assign in_ch[1] = item.red;
    assign in_ch[2] = item.blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && item.valid)
        begin
            s1_func_reg   <= item.func;
            s1_bypass_reg <= (brightness_reg == lpse_pkg::FULL_SCALE);
            for (int c = 0; c < 3; c++)
            begin
                s1_raw_reg[c] <= in_ch[c];
                s1_sum_reg[c] <= {8'd0, in_ch[c]} * {8'd0, brightness_reg}
                                 + lpse_pkg::ROUND_HALF;
            end
        end
    end

    // ---------------- stage 2: divide by 255, line coding ----------------
    logic        s2_func_reg;
    logic [95:0] s2_code_reg;
    logic [6:0]  s2_len_reg;
    logic [7:0]  dim [3];
    logic [16:0] div_tmp [3];
    logic [6:0]  gap_len;

    // y/255 == (y + 1 + (y >> 8)) >> 8 for any y up to 65152, the largest stage-1 sum
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div_tmp[c] = {1'b0, s1_sum_reg[c]} + 17'd1 + {9'd0, s1_sum_reg[c][15:8]};
            dim[c]     = s1_bypass_reg ? s1_raw_reg[c] : div_tmp[c][15:8];
        end
    end

    // Gap length clamped to 1..64
    always_comb
    begin
        if (gap_length_reg == 7'd0)
            gap_len = 7'd1;
        else if (gap_length_reg > lpse_pkg::GAP_MAX)
            gap_len = lpse_pkg::GAP_MAX;
        else
            gap_len = gap_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_func_reg <= s1_func_reg;
            s2_code_reg <= {lpse_pkg::encode_channel(dim[0]),
                            lpse_pkg::encode_channel(dim[1]),
                            lpse_pkg::encode_channel(dim[2])};
            s2_len_reg  <= gap_len;
        end
    end

    // ---------------- stage 3: byte serializer ----------------
    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (ser_load)
        begin
            if (s2_func_reg == lpse_pkg::FUNC_GAP)
            begin
                cnt_next  = s2_len_reg;
                data_next = 96'd0;
            end
            else
            begin
                cnt_next  = lpse_pkg::BYTES_PER_PIXEL;
                data_next = s2_code_reg;
            end
        end
        else if (out_fire)
        begin
            cnt_next  = cnt_reg - 7'd1;
            data_next = {data_reg[87:0], 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign line.valid       = (cnt_reg != 7'd0);
    assign line.spi_byte    = data_reg[95:88];
    assign line.last_of_run = (cnt_reg == 7'd1);

    // ---------------- assertions ----------------
    `LPSE_ASSERT(a_cnt_range, cnt_reg <= lpse_pkg::GAP_MAX)
    `LPSE_ASSERT(a_stall_full, !item.ready |-> (s1_valid_reg && s2_valid_reg))
    `LPSE_ASSERT_NEXT(a_hold_count, line.valid && !line.ready, cnt_reg == $past(cnt_reg))

endmodule
